[src/spdq_pkg.sv]
`timescale 1ns / 1ps
// spdq_pkg: shared types and constants of the serial packet deframer queue
// no dependencies; imported by the top level and the packet store

package spdq_pkg;

  typedef enum logic [1:0] {
    MODE_BYTE    = 2'd0,
    MODE_TICK    = 2'd1,
    MODE_READ    = 2'd2,
    MODE_RELEASE = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    REG_START_BYTE  = 3'd0,
    REG_END_FIRST   = 3'd1,
    REG_END_SECOND  = 3'd2,
    REG_LENGTH_POS  = 3'd3,
    REG_TIMEOUT_LIM = 3'd4
  } reg_idx_e;

  localparam logic [7:0] START_BYTE_RST  = 8'hAA;
  localparam logic [7:0] END_FIRST_RST   = 8'h0D;
  localparam logic [7:0] END_SECOND_RST  = 8'h0A;
  localparam logic [4:0] LENGTH_POS_RST  = 5'd3;
  localparam logic [7:0] TIMEOUT_LIM_RST = 8'd20;

  localparam int unsigned LEN_OFFSET = 6;
  localparam logic [7:0]  TICK_MAX   = 8'hFF;

  // write port of the packet store
  typedef struct packed {
    logic        en;
    logic [11:0] addr;
    logic [7:0]  data;
  } store_wr_t;

endpackage

[src/spdq_store.sv]
`timescale 1ns / 1ps
// spdq_store: packet byte store, one write port and two registered read ports
// depends on spdq_pkg for the write port struct; reads return write data on collision

module spdq_store import spdq_pkg::*; #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7
) (
  input  logic          clk_i,
  input  store_wr_t     wr_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_a_i,
  input  logic [AW-1:0] rd_addr_b_i,
  output logic [7:0]    rd_data_a_o,
  output logic [7:0]    rd_data_b_o
);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] waddr;

  assign waddr = wr_i.addr[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[waddr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_i.en && (waddr == rd_addr_a_i)) begin
        rd_data_a_o <= wr_i.data;
      end else begin
        rd_data_a_o <= mem[rd_addr_a_i];
      end
      if (wr_i.en && (waddr == rd_addr_b_i)) begin
        rd_data_b_o <= wr_i.data;
      end else begin
        rd_data_b_o <= mem[rd_addr_b_i];
      end
    end
  end

endmodule

[src/serial_packet_deframer_queue.sv]
`timescale 1ns / 1ps
// serial_packet_deframer_queue: deframes received bytes into a ring of packet slots
// depends on spdq_pkg and spdq_store
// an input transaction passes the input stage (with store read) and then the result register
// throughput: one transaction per cycle while in_stall_o is low (one store write port per item)
// after reset the store is cleared one byte per cycle over all QUEUE_DEPTH*PACKET_BYTES bytes
// (128 by default) with in_stall_o high; config writes are taken during that pass

module serial_packet_deframer_queue import spdq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH  = 4,
  parameter int unsigned PACKET_BYTES = 32,
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [1:0]    mode_i,
  input  logic [7:0]    rx_byte_i,
  input  logic [4:0]    read_index_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic          packet_accepted_o,
  output logic          packet_dropped_o,
  output logic [CW-1:0] queue_count_o,
  output logic [7:0]    read_data_o,
  output logic          read_valid_o,
  output logic          receiving_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int unsigned DEPTH    = QUEUE_DEPTH * PACKET_BYTES;
  localparam int unsigned AW       = $clog2(DEPTH);
  localparam int unsigned IW       = $clog2(PACKET_BYTES);
  localparam int unsigned SW       = $clog2(QUEUE_DEPTH);
  localparam int unsigned MODSTEPS = (PACKET_BYTES >= 32) ? 1 : (32 / PACKET_BYTES);

  function automatic logic [IW-1:0] wrap_idx(input logic [4:0] x);
    logic [8:0] t;
    t = 9'(x);
    for (int k = 0; k < MODSTEPS; k++) begin
      if (t >= 9'(PACKET_BYTES)) t = t - 9'(PACKET_BYTES);
    end
    return t[IW-1:0];
  endfunction

  function automatic logic [AW-1:0] slot_addr(input logic [SW-1:0] s, input logic [IW-1:0] i);
    return AW'(s) * AW'(PACKET_BYTES) + AW'(i);
  endfunction

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    return (s == SW'(QUEUE_DEPTH - 1)) ? '0 : s + SW'(1);
  endfunction

  // config registers
  logic [7:0] start_q, eb1_q, eb2_q, tlim_q;
  logic [4:0] lp_q, lp_n;
  logic       cfg_wr;
  reg_idx_e   cfg_idx;

  // input stage
  logic          s1_valid_q, s1_move, in_accept;
  mode_e         s1_mode_q;
  logic [7:0]    s1_rxb_q;
  logic [IW-1:0] s1_ridx_q;

  // deframer state
  logic          rx_q, rx_d;
  logic [IW-1:0] bi_q, bi_d;
  logic [7:0]    prev_q, prev_d, tick_q, tick_d;
  logic          tmo_q, tmo_d;
  logic [SW-1:0] head_q, head_d, tail_q, tail_d, head_n, tail_n;
  logic [CW-1:0] used_q, used_d;
  logic [7:0]    len_q [QUEUE_DEPTH];

  // clearing pass
  logic          clr_q;
  logic [AW-1:0] clr_addr_q;

  // store
  store_wr_t     wr;
  logic          st_we;
  logic [AW-1:0] st_addr;
  logic [7:0]    st_data, rd_a, rd_b;

  // step results
  logic       acc_c, drop_c, rvalid_c;
  logic [7:0] rdata_c;

  // result register
  logic          out_valid_q, acc_q, drop_q, rvalid_q, recv_q;
  logic [CW-1:0] count_q;
  logic [7:0]    rdata_q;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= START_BYTE_RST;
      eb1_q   <= END_FIRST_RST;
      eb2_q   <= END_SECOND_RST;
      lp_q    <= LENGTH_POS_RST;
      tlim_q  <= TIMEOUT_LIM_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_START_BYTE:  start_q <= pwdata[7:0];
        REG_END_FIRST:   eb1_q   <= pwdata[7:0];
        REG_END_SECOND:  eb2_q   <= pwdata[7:0];
        REG_LENGTH_POS:  lp_q    <= pwdata[4:0];
        REG_TIMEOUT_LIM: tlim_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_START_BYTE:  prdata = 32'(start_q);
      REG_END_FIRST:   prdata = 32'(eb1_q);
      REG_END_SECOND:  prdata = 32'(eb2_q);
      REG_LENGTH_POS:  prdata = 32'(lp_q);
      REG_TIMEOUT_LIM: prdata = 32'(tlim_q);
      default:         prdata = '0;
    endcase
  end

  // length position as seen by a transaction accepted at this edge
  assign lp_n = (cfg_wr && (cfg_idx == REG_LENGTH_POS)) ? pwdata[4:0] : lp_q;

  // handshakes
  assign s1_move    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = clr_q || (s1_valid_q && !s1_move);
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_mode_q <= mode_e'(mode_i);
      s1_rxb_q  <= rx_byte_i;
      s1_ridx_q <= wrap_idx(read_index_i);
    end
  end

  // one step of the deframer
  always_comb begin
    rx_d     = rx_q;
    bi_d     = bi_q;
    prev_d   = prev_q;
    tick_d   = tick_q;
    tmo_d    = tmo_q;
    head_d   = head_q;
    tail_d   = tail_q;
    used_d   = used_q;
    acc_c    = 1'b0;
    drop_c   = 1'b0;
    rvalid_c = 1'b0;
    rdata_c  = '0;
    st_we    = 1'b0;
    st_addr  = slot_addr(head_q, '0);
    st_data  = s1_rxb_q;
    case (s1_mode_q)
      MODE_BYTE: begin
        prev_d = s1_rxb_q;
        if (!rx_q) begin
          bi_d = '0;
          if (used_q >= CW'(QUEUE_DEPTH)) begin
            drop_c = (s1_rxb_q == start_q);
          end else begin
            st_we = 1'b1;
            if (s1_rxb_q == start_q) begin
              rx_d   = 1'b1;
              bi_d   = IW'(1);
              tick_d = '0;
              tmo_d  = 1'b0;
            end
          end
        end else begin
          st_we   = 1'b1;
          st_addr = slot_addr(head_q, bi_q);
          if ((s1_rxb_q == eb2_q) && (prev_q == eb1_q)) begin
            if ((9'(bi_q) >= 9'(LEN_OFFSET)) && (9'(lp_q) < 9'(bi_q)) &&
                (9'(rd_b) == 9'(bi_q) - 9'(LEN_OFFSET)) &&
                (used_q < CW'(QUEUE_DEPTH))) begin
              head_d = slot_inc(head_q);
              used_d = used_q + CW'(1);
              acc_c  = 1'b1;
            end else begin
              drop_c = 1'b1;
            end
            rx_d = 1'b0;
            bi_d = '0;
          end else if (9'(bi_q) >= 9'(PACKET_BYTES - 1)) begin
            drop_c = 1'b1;
            rx_d   = 1'b0;
            bi_d   = '0;
          end else begin
            bi_d = bi_q + IW'(1);
            if (tmo_q) begin
              drop_c = 1'b1;
              rx_d   = 1'b0;
              bi_d   = '0;
            end
          end
        end
      end
      MODE_TICK: begin
        if (tick_q > tlim_q) begin
          tmo_d = 1'b1;
        end else if (tick_q != TICK_MAX) begin
          tick_d = tick_q + 8'd1;
        end
      end
      MODE_READ: begin
        if (used_q != '0) begin
          rvalid_c = 1'b1;
          rdata_c  = (s1_ridx_q == '0) ? len_q[tail_q] : rd_a;
        end
      end
      MODE_RELEASE: begin
        if (used_q != '0) begin
          rvalid_c = 1'b1;
          used_d   = used_q - CW'(1);
          tail_d   = slot_inc(tail_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_q   <= 1'b0;
      bi_q   <= '0;
      prev_q <= '0;
      tick_q <= '0;
      tmo_q  <= 1'b0;
      head_q <= '0;
      tail_q <= '0;
      used_q <= '0;
    end else if (s1_move) begin
      rx_q   <= rx_d;
      bi_q   <= bi_d;
      prev_q <= prev_d;
      tick_q <= tick_d;
      tmo_q  <= tmo_d;
      head_q <= head_d;
      tail_q <= tail_d;
      used_q <= used_d;
    end
  end

  // read byte 0 of a queued packet returns its end index, held here in len_q
  always_ff @(posedge clk_i) begin
    if (s1_move && acc_c) begin
      len_q[head_q] <= 8'(bi_q);
    end
  end

  // clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clr_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + AW'(1);
      end
    end
  end

  // store access, read addresses follow the state left by the item in flight
  assign head_n = s1_move ? head_d : head_q;
  assign tail_n = s1_move ? tail_d : tail_q;

  assign wr.en   = clr_q || (s1_move && st_we);
  assign wr.addr = clr_q ? 12'(clr_addr_q) : 12'(st_addr);
  assign wr.data = clr_q ? 8'd0 : st_data;

  spdq_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i       (clk_i),
    .wr_i        (wr),
    .rd_en_i     (in_accept),
    .rd_addr_a_i (slot_addr(tail_n, wrap_idx(read_index_i))),
    .rd_addr_b_i (slot_addr(head_n, wrap_idx(lp_n))),
    .rd_data_a_o (rd_a),
    .rd_data_b_o (rd_b)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      acc_q    <= acc_c;
      drop_q   <= drop_c;
      count_q  <= used_d;
      rdata_q  <= rdata_c;
      rvalid_q <= rvalid_c;
      recv_q   <= rx_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign packet_accepted_o = acc_q;
  assign packet_dropped_o  = drop_q;
  assign queue_count_o     = count_q;
  assign read_data_o       = rdata_q;
  assign read_valid_o      = rvalid_q;
  assign receiving_o       = recv_q;

`ifndef NO_ASSERTIONS
  a_acc_drop_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(packet_accepted_o && packet_dropped_o))
    else $error("accept and drop in one result");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= CW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_acc_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_move && acc_c) |=> (!rx_q && (used_q != '0)))
    else $error("accepted packet left receiver busy or queue empty");

  a_no_item_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> (!s1_valid_q && !out_valid_q))
    else $error("transaction in flight during clearing pass");

  a_hold_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_move) |=> (s1_valid_q && $stable(s1_rxb_q)))
    else $error("held input stage lost its item");
`endif

endmodule

[test/tb_serial_packet_deframer_queue.sv]
`timescale 1ns / 1ps
// tb_serial_packet_deframer_queue: self-checking bench for the packet deframer queue
// depends on spdq_pkg and serial_packet_deframer_queue; predicts every result transaction
// and checks it field by field under random sender idling and receiver stalls

module tb_serial_packet_deframer_queue;
  import spdq_pkg::*;

  localparam int QDEPTH     = 4;
  localparam int PBYTES     = 32;
  localparam int WDOG_LIMIT = 4000;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] rx_byte;
    logic [4:0] read_index;
  } deframer_item_t;

  typedef struct packed {
    logic       accepted;
    logic       dropped;
    logic [2:0] count;
    logic [7:0] rdata;
    logic       rvalid;
    logic       busy;
  } deframer_result_t;

  logic        clk_i        = 1'b0;
  logic        rst_ni       = 1'b0;
  logic        in_valid_i   = 1'b0;
  logic        in_stall_o;
  logic [1:0]  mode_i       = '0;
  logic [7:0]  rx_byte_i    = '0;
  logic [4:0]  read_index_i = '0;
  logic        out_valid_o;
  logic        out_stall_i  = 1'b0;
  logic        packet_accepted_o;
  logic        packet_dropped_o;
  logic [2:0]  queue_count_o;
  logic [7:0]  read_data_o;
  logic        read_valid_o;
  logic        receiving_o;
  logic        psel         = 1'b0;
  logic        penable      = 1'b0;
  logic        pwrite       = 1'b0;
  logic [4:0]  paddr        = '0;
  logic [31:0] pwdata       = '0;
  logic [31:0] prdata;
  logic        pready;

  serial_packet_deframer_queue uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .mode_i            (mode_i),
    .rx_byte_i         (rx_byte_i),
    .read_index_i      (read_index_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .packet_accepted_o (packet_accepted_o),
    .packet_dropped_o  (packet_dropped_o),
    .queue_count_o     (queue_count_o),
    .read_data_o       (read_data_o),
    .read_valid_o      (read_valid_o),
    .receiving_o       (receiving_o),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // predictor state and register copy
  logic [7:0] cfg_start, cfg_end1, cfg_end2, cfg_tmo;
  logic [4:0] cfg_len_pos;
  bit         rx_busy, timed_out;
  int         byte_pos, tick_cnt, wr_slot, rd_slot, used_slots;
  logic [7:0] last_rx;
  logic [7:0] pkt_mem [0:QDEPTH*PBYTES-1];

  deframer_item_t   pending_items[$];
  deframer_result_t expected_results[$];
  int               issued_cnt, checked_cnt, err_cnt, stall_cycles;
  int               send_idle_pct, recv_stall_pct;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic void reset_deframer();
    cfg_start   = START_BYTE_RST;
    cfg_end1    = END_FIRST_RST;
    cfg_end2    = END_SECOND_RST;
    cfg_len_pos = LENGTH_POS_RST;
    cfg_tmo     = TIMEOUT_LIM_RST;
    rx_busy     = 1'b0;
    timed_out   = 1'b0;
    byte_pos    = 0;
    tick_cnt    = 0;
    wr_slot     = 0;
    rd_slot     = 0;
    used_slots  = 0;
    last_rx     = '0;
    foreach (pkt_mem[i]) pkt_mem[i] = '0;
  endfunction

  function automatic deframer_result_t predict_deframer(deframer_item_t it);
    deframer_result_t r;
    logic [7:0]       last, lenb;
    int               base;
    r = '0;
    case (it.mode)
      MODE_BYTE: begin
        last    = last_rx;
        base    = wr_slot * PBYTES;
        last_rx = it.rx_byte;
        if (!rx_busy) begin
          byte_pos = 0;
          if (used_slots >= QDEPTH) begin
            if (it.rx_byte == cfg_start) r.dropped = 1'b1;
          end else begin
            pkt_mem[base] = it.rx_byte;
            if (it.rx_byte == cfg_start) begin
              rx_busy   = 1'b1;
              byte_pos  = 1;
              tick_cnt  = 0;
              timed_out = 1'b0;
            end
          end
        end else begin
          pkt_mem[base + byte_pos] = it.rx_byte;
          if (it.rx_byte == cfg_end2 && last == cfg_end1) begin
            lenb = pkt_mem[base + int'(cfg_len_pos)];
            if (byte_pos >= int'(LEN_OFFSET) && int'(cfg_len_pos) < byte_pos &&
                int'(lenb) == byte_pos - int'(LEN_OFFSET) && used_slots < QDEPTH) begin
              pkt_mem[base] = byte_pos[7:0];
              wr_slot       = (wr_slot + 1) % QDEPTH;
              used_slots++;
              r.accepted = 1'b1;
            end else begin
              r.dropped = 1'b1;
            end
            rx_busy  = 1'b0;
            byte_pos = 0;
          end else if (byte_pos >= PBYTES - 1) begin
            r.dropped = 1'b1;
            rx_busy   = 1'b0;
            byte_pos  = 0;
          end else begin
            byte_pos++;
            if (timed_out) begin
              r.dropped = 1'b1;
              rx_busy   = 1'b0;
              byte_pos  = 0;
            end
          end
        end
      end
      MODE_TICK: begin
        if (tick_cnt > int'(cfg_tmo)) timed_out = 1'b1;
        else if (tick_cnt < int'(TICK_MAX)) tick_cnt++;
      end
      MODE_READ: begin
        if (used_slots > 0) begin
          r.rvalid = 1'b1;
          r.rdata  = pkt_mem[rd_slot * PBYTES + int'(it.read_index)];
        end
      end
      default: begin
        if (used_slots > 0) begin
          r.rvalid = 1'b1;
          used_slots--;
          rd_slot = (rd_slot + 1) % QDEPTH;
        end
      end
    endcase
    r.count = used_slots[2:0];
    r.busy  = rx_busy;
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] expv, logic [31:0] actv);
    if (expv !== actv) begin
      $error("%s: expected %0d, got %0d", name, expv, actv);
      err_cnt++;
    end
  endtask

  // input driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_items
    deframer_item_t cur, nxt;
    bit             fire;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      fire = in_valid_i && !in_stall_o;
      if (fire) begin
        cur.mode       = mode_e'(mode_i);
        cur.rx_byte    = rx_byte_i;
        cur.read_index = read_index_i;
        expected_results.push_back(predict_deframer(cur));
      end
      if (!in_valid_i || fire) begin
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = pending_items.pop_front();
          in_valid_i   <= 1'b1;
          mode_i       <= nxt.mode;
          rx_byte_i    <= nxt.rx_byte;
          read_index_i <= nxt.read_index;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin : watch_results
    deframer_result_t exp_r;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        checked_cnt++;
        if (expected_results.size() == 0) begin
          $error("result transaction with nothing expected");
          err_cnt++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("packet_accepted", 32'(exp_r.accepted), 32'(packet_accepted_o));
          check_field("packet_dropped", 32'(exp_r.dropped), 32'(packet_dropped_o));
          check_field("queue_count", 32'(exp_r.count), 32'(queue_count_o));
          check_field("read_data", 32'(exp_r.rdata), 32'(read_data_o));
          check_field("read_valid", 32'(exp_r.rvalid), 32'(read_valid_o));
          check_field("receiving", 32'(exp_r.busy), 32'(receiving_o));
        end
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= WDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  task automatic write_register(reg_idx_e idx, logic [7:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_START_BYTE:  cfg_start   = value;
      REG_END_FIRST:   cfg_end1    = value;
      REG_END_SECOND:  cfg_end2    = value;
      REG_LENGTH_POS:  cfg_len_pos = value[4:0];
      REG_TIMEOUT_LIM: cfg_tmo     = value;
      default: ;
    endcase
  endtask

  task automatic set_config(logic [7:0] s, logic [7:0] e1, logic [7:0] e2,
                            logic [4:0] lp, logic [7:0] tmo);
    write_register(REG_START_BYTE, s);
    write_register(REG_END_FIRST, e1);
    write_register(REG_END_SECOND, e2);
    write_register(REG_LENGTH_POS, {3'd0, lp});
    write_register(REG_TIMEOUT_LIM, tmo);
  endtask

  task automatic push_item(mode_e m, logic [7:0] b, logic [4:0] idx);
    deframer_item_t it;
    it.mode       = m;
    it.rx_byte    = b;
    it.read_index = idx;
    pending_items.push_back(it);
    issued_cnt++;
  endtask

  // start, body with length byte, end marker; sometimes a wrong length or a tick run
  task automatic gen_packet();
    logic [7:0] pkt [0:PBYTES-1];
    int         lo, hi, e, tick_at, tick_run, lp, tmo;
    bit         fixed_i, fixed_p;
    lp  = int'(cfg_len_pos);
    tmo = int'(cfg_tmo);
    lo = (lp + 2 > int'(LEN_OFFSET)) ? lp + 2 : int'(LEN_OFFSET);
    if (lo > PBYTES - 1) lo = PBYTES - 1;
    hi = (lo + 6 > PBYTES - 1) ? PBYTES - 1 : lo + 6;
    e  = ($urandom_range(0, 9) == 0) ? $urandom_range(lo, PBYTES - 1) : $urandom_range(lo, hi);
    foreach (pkt[i]) pkt[i] = 8'($urandom);
    pkt[0] = cfg_start;
    if (lp < e) pkt[lp] = 8'(e - int'(LEN_OFFSET) + int'($urandom_range(0, 9) == 0));
    pkt[e-1] = cfg_end1;
    pkt[e]   = cfg_end2;
    for (int i = 1; i < e; i++) begin
      if (pkt[i] == cfg_end2 && pkt[i-1] == cfg_end1) begin
        fixed_i = (i == lp) || (i == e - 1);
        fixed_p = (i - 1 == 0) || (i - 1 == lp);
        if (!fixed_i) pkt[i] = pkt[i] + 8'd1;
        else if (!fixed_p) pkt[i-1] = pkt[i-1] + 8'd1;
      end
    end
    tick_at  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, e) : -1;
    tick_run = $urandom_range(1, (tmo + 3 > 40) ? 40 : tmo + 3);
    for (int i = 0; i <= e; i++) begin
      if (i == tick_at) repeat (tick_run) push_item(MODE_TICK, 8'($urandom), 5'($urandom));
      push_item(MODE_BYTE, pkt[i], 5'($urandom));
    end
  endtask

  task automatic gen_broken();
    case ($urandom_range(0, 2))
      0: begin
        push_item(MODE_BYTE, cfg_start, 5'($urandom));
        repeat ($urandom_range(0, 5)) push_item(MODE_BYTE, 8'($urandom), 5'($urandom));
      end
      1: begin
        push_item(MODE_BYTE, cfg_start, 5'($urandom));
        repeat (PBYTES + 1) push_item(MODE_BYTE, 8'($urandom), 5'($urandom));
      end
      default: begin
        push_item(MODE_BYTE, cfg_start, 5'($urandom));
        push_item(MODE_BYTE, cfg_end1, 5'($urandom));
        push_item(MODE_BYTE, cfg_end2, 5'($urandom));
      end
    endcase
  endtask

  task automatic gen_phase(int n);
    int target, pick;
    target = issued_cnt + n;
    while (issued_cnt < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        gen_packet();
      end else if (pick < 70) begin
        repeat ($urandom_range(1, 4))
          push_item(MODE_READ, 8'($urandom),
                    5'($urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 31)));
        if ($urandom_range(0, 9) < 6) push_item(MODE_RELEASE, 8'($urandom), 5'($urandom));
      end else if (pick < 80) begin
        push_item(MODE_RELEASE, 8'($urandom), 5'($urandom));
      end else if (pick < 88) begin
        gen_broken();
      end else if (pick < 94) begin
        repeat ($urandom_range(1, 3))
          push_item(mode_e'(2'($urandom_range(0, 3))), 8'($urandom), 5'($urandom));
      end else begin
        repeat ($urandom_range(1, 5)) push_item(MODE_TICK, 8'($urandom), 5'($urandom));
      end
    end
  endtask

  task automatic wait_drained();
    while (checked_cnt < issued_cnt) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    reset_deframer();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_config(START_BYTE_RST, END_FIRST_RST, END_SECOND_RST, LENGTH_POS_RST,
               TIMEOUT_LIM_RST);

    // empty queue, a good minimal packet, reads at both index extremes
    push_item(MODE_READ, 8'h00, 5'd0);
    push_item(MODE_RELEASE, 8'hFF, 5'd31);
    push_item(MODE_BYTE, 8'hAA, 5'd0);
    push_item(MODE_BYTE, 8'h11, 5'd0);
    push_item(MODE_BYTE, 8'h22, 5'd0);
    push_item(MODE_BYTE, 8'h00, 5'd0);
    push_item(MODE_BYTE, 8'hFF, 5'd31);
    push_item(MODE_BYTE, 8'h0D, 5'd0);
    push_item(MODE_BYTE, 8'h0A, 5'd0);
    push_item(MODE_READ, 8'h00, 5'd0);
    push_item(MODE_READ, 8'hFF, 5'd31);
    push_item(MODE_READ, 8'h00, 5'd3);
    push_item(MODE_TICK, 8'h00, 5'd0);
    // short packet, then a wrong length byte
    push_item(MODE_BYTE, 8'hAA, 5'd0);
    push_item(MODE_BYTE, 8'h0D, 5'd0);
    push_item(MODE_BYTE, 8'h0A, 5'd0);
    push_item(MODE_BYTE, 8'hAA, 5'd0);
    push_item(MODE_BYTE, 8'h01, 5'd0);
    push_item(MODE_BYTE, 8'h02, 5'd0);
    push_item(MODE_BYTE, 8'h05, 5'd0);
    push_item(MODE_BYTE, 8'h03, 5'd0);
    push_item(MODE_BYTE, 8'h0D, 5'd0);
    push_item(MODE_BYTE, 8'h0A, 5'd0);
    push_item(MODE_RELEASE, 8'h00, 5'd0);
    push_item(MODE_BYTE, 8'h00, 5'd0);
    gen_phase(200);
    wait_drained();

    set_config(8'h00, 8'hFF, 8'hFF, 5'd1, 8'd0);
    send_idle_pct = 52;
    gen_phase(200);
    wait_drained();

    set_config(8'hFF, 8'h00, 8'hFE, 5'd31, 8'd255);
    send_idle_pct  = 0;
    recv_stall_pct = 52;
    gen_phase(100);
    wait_drained();

    set_config(8'($urandom), 8'($urandom), 8'($urandom), 5'($urandom_range(1, 20)),
               8'($urandom_range(0, 40)));
    send_idle_pct  = 20;
    recv_stall_pct = 20;
    gen_phase(220);
    wait_drained();

    set_config(8'($urandom), 8'($urandom), 8'($urandom), 5'($urandom_range(2, 10)),
               8'($urandom_range(0, 8)));
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    gen_phase(200);
    wait_drained();

    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
src/spdq_pkg.sv
src/spdq_store.sv
src/serial_packet_deframer_queue.sv
test/tb_serial_packet_deframer_queue.sv
